[rtl/core/utf8_to_utf32_stream_decoder_assert.svh]
// Assertion macros for the UTF-8 to UTF-32 stream decoder.
// All checks are clocked on clk_i and disabled while rst_ni is low.
`ifndef UTF8_TO_UTF32_STREAM_DECODER_ASSERT_SVH
`define UTF8_TO_UTF32_STREAM_DECODER_ASSERT_SVH

// Combinational invariant, checked at every edge.
`define UTD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define UTD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/utd_pkg.sv]
package utd_pkg;

  // Code point width of the lenient legacy form
  localparam int unsigned CpW = 31;

  // Deepest open sequence: six-byte lead leaves five continuations
  localparam logic [2:0] MaxPending = 3'd5;

  // Result slots in the output queue
  localparam logic [2:0] OutDepth = 3'd2;

  // Result counts of one byte
  localparam logic [1:0] NoResult   = 2'd0;
  localparam logic [1:0] OneResult  = 2'd1;
  localparam logic [1:0] TwoResults = 2'd2;

  // One result item
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           last;
  } utd_result_t;

  // What one byte does: results it causes and the state it leaves
  typedef struct packed {
    logic [1:0]     count;
    utd_result_t    r0;
    utd_result_t    r1;
    logic [CpW-1:0] partial;
    logic [2:0]     pending;
  } utd_decode_t;

endpackage

[rtl/core/utd_decode.sv]
module utd_decode (
  input  logic [7:0]                 byte_i,
  input  logic [utd_pkg::CpW-1:0]    partial_i,
  input  logic [2:0]                 pending_i,
  output utd_pkg::utd_decode_t       dec_o
);

  logic [2:0]                pend;
  logic [4:0]                shamt;
  logic [utd_pkg::CpW-1:0]   cont_val;
  logic                      lead_emit;
  logic [utd_pkg::CpW-1:0]   lead_cp;
  logic [utd_pkg::CpW-1:0]   lead_partial;
  logic [2:0]                lead_pending;

  // Out-of-range counts behave as the deepest sequence
  assign pend = (pending_i > utd_pkg::MaxPending) ? utd_pkg::MaxPending : pending_i;

  // Continuation bits land at 6*(pending-1)
  always_comb begin
    case (pend)
      3'd1:    shamt = 5'd0;
      3'd2:    shamt = 5'd6;
      3'd3:    shamt = 5'd12;
      3'd4:    shamt = 5'd18;
      3'd5:    shamt = 5'd24;
      default: shamt = 5'd0;
    endcase
  end

  assign cont_val = partial_i | ({25'b0, byte_i[5:0]} << shamt);

  // Byte taken as a lead
  always_comb begin
    lead_emit    = 1'b0;
    lead_cp      = '0;
    lead_partial = '0;
    lead_pending = 3'd0;
    if (byte_i == 8'h00) begin
      // terminator: nothing
    end else if (!byte_i[7]) begin
      lead_emit = 1'b1;
      lead_cp   = {23'b0, byte_i};
    end else if (byte_i >= 8'hFE) begin
      // invalid lead, emits zero
      lead_emit = 1'b1;
    end else if (byte_i[7:5] == 3'b110) begin
      lead_partial = {20'b0, byte_i[4:0], 6'b0};
      lead_pending = 3'd1;
    end else if (byte_i[7:4] == 4'hE || byte_i[7:6] == 2'b10) begin
      // stray continuations count as three-byte leads
      lead_partial = {15'b0, byte_i[3:0], 12'b0};
      lead_pending = 3'd2;
    end else if (byte_i[7:3] == 5'b11110) begin
      lead_partial = {10'b0, byte_i[2:0], 18'b0};
      lead_pending = 3'd3;
    end else if (byte_i[7:2] == 6'b111110) begin
      lead_partial = {5'b0, byte_i[1:0], 24'b0};
      lead_pending = 3'd4;
    end else begin
      lead_partial = {byte_i[0], 30'b0};
      lead_pending = 3'd5;
    end
  end

  // Combine continuation, flush and lead paths
  always_comb begin
    dec_o         = '0;
    dec_o.partial = partial_i;
    dec_o.pending = pend;
    if (pend != 3'd0 && byte_i[7]) begin
      dec_o.partial = cont_val;
      dec_o.pending = pend - 3'd1;
      if (pend == 3'd1) begin
        dec_o.count         = utd_pkg::OneResult;
        dec_o.r0.code_point = cont_val;
        dec_o.r0.last       = 1'b1;
        dec_o.partial       = '0;
      end
    end else begin
      dec_o.count = utd_pkg::NoResult;
      // cut-short sequence goes out first
      if (pend != 3'd0) begin
        dec_o.count         = utd_pkg::OneResult;
        dec_o.r0.code_point = partial_i;
        dec_o.r0.last       = (byte_i == 8'h00);
      end
      if (lead_emit) begin
        if (pend != 3'd0) begin
          dec_o.count         = utd_pkg::TwoResults;
          dec_o.r1.code_point = lead_cp;
          dec_o.r1.last       = 1'b1;
        end else begin
          dec_o.count         = utd_pkg::OneResult;
          dec_o.r0.code_point = lead_cp;
          dec_o.r0.last       = 1'b1;
        end
      end
      dec_o.partial = lead_partial;
      dec_o.pending = lead_pending;
    end
  end

endmodule

[rtl/core/utd_out_fifo.sv]
module utd_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            push_count_i,
  input  utd_pkg::utd_result_t  r0_i,
  input  utd_pkg::utd_result_t  r1_i,
  input  logic                  pop_i,
  output utd_pkg::utd_result_t  head_o,
  output logic [1:0]            level_o
);

  utd_pkg::utd_result_t mem_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           count_q, count_d;

  // Pointer and level update; a double push leaves the write pointer in place
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_count_i[0];
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q - {1'b0, pop_i} + push_count_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage
  always_ff @(posedge clk_i) begin
    if (push_count_i != utd_pkg::NoResult) begin
      mem_q[wr_ptr_q] <= r0_i;
    end
    if (push_count_i == utd_pkg::TwoResults) begin
      mem_q[~wr_ptr_q] <= r1_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign level_o = count_q;

endmodule

[rtl/core/utf8_to_utf32_stream_decoder.sv]
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+-------------------------------
// input    | in        | in_valid_i / in_ready_o  | in_byte_i[7:0]
// output   | out       | out_valid_o / out_ready_i| code_point_o[30:0], last_of_run_o
//
// One byte per cycle while the output queue has room: a byte is held in the input
// register, is decoded there and its zero to two results go into a two-slot output queue.
// A byte is decoded once the queue, counting this cycle's transfer out, has
// room for all its results; a stalled output therefore holds the input register.
// A result is offered once its byte has been decoded out of the input register
// and written into the output queue; the queue head drives the outputs.
// Reset clears the decode state, the input register's valid flag and the queue.
`include "utf8_to_utf32_stream_decoder_assert.svh"

module utf8_to_utf32_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [30:0] code_point_o,
  output logic        last_of_run_o
);

  logic                          in_vld_q;
  logic [7:0]                    in_byte_q;
  logic [utd_pkg::CpW-1:0]       partial_q;
  logic [2:0]                    pending_q;
  utd_pkg::utd_decode_t          dec;
  utd_pkg::utd_result_t          head;
  logic [1:0]                    level;
  logic                          pop;
  logic [2:0]                    occ;
  logic                          consume;
  logic [1:0]                    push_count;

  // Decode of the held byte
  utd_decode u_decode (
    .byte_i    (in_byte_q),
    .partial_i (partial_q),
    .pending_i (pending_q),
    .dec_o     (dec)
  );

  // Room check includes the slot freed by this cycle's transfer out
  assign pop        = out_ready_i && (level != 2'd0);
  assign occ        = {1'b0, level} - {2'b0, pop};
  assign consume    = in_vld_q && ((occ + {1'b0, dec.count}) <= utd_pkg::OutDepth);
  assign push_count = consume ? dec.count : utd_pkg::NoResult;
  assign in_ready_o = !in_vld_q || consume;

  // Input register and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      partial_q <= '0;
      pending_q <= 3'd0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (consume) begin
        partial_q <= dec.partial;
        pending_q <= dec.pending;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  // Output queue
  utd_out_fifo u_out_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_count_i (push_count),
    .r0_i         (dec.r0),
    .r1_i         (dec.r1),
    .pop_i        (pop),
    .head_o       (head),
    .level_o      (level)
  );

  assign out_valid_o   = (level != 2'd0);
  assign code_point_o  = head.code_point;
  assign last_of_run_o = head.last;

  // Checks
  `UTD_ASSERT_ALWAYS(a_pending_range, pending_q <= utd_pkg::MaxPending, "pending count out of range")
  `UTD_ASSERT_ALWAYS(a_pair_order, (push_count != utd_pkg::TwoResults) || (!dec.r0.last && dec.r1.last), "bad last flags on result pair")
  `UTD_ASSERT_NEXT(a_held_byte, in_vld_q && !consume, in_vld_q && $stable(in_byte_q), "held byte lost")
  `UTD_ASSERT_ALWAYS(a_queue_bound, level <= 2'd2, "output queue overflow")

endmodule
